### hw/rtl/mare_pkg.sv
// package for the moving average report-by-exception block: sizes, codes and types
`timescale 1ns / 1ps
`default_nettype none
package mare_pkg;

	localparam int STORAGE_SIZE = 16;
	localparam int IDX_W = (STORAGE_SIZE > 1) ? $clog2(STORAGE_SIZE) : 1;
	localparam int CNT_W = $clog2(STORAGE_SIZE + 1);
	localparam int VAL_W = 16;
	localparam int SUM_W = ((STORAGE_SIZE > 1) ? $clog2(STORAGE_SIZE) : 0) + VAL_W + 1;
	localparam int NUM_W = SUM_W;
	localparam int DEN_W = CNT_W + 1;
	localparam int DIVC_W = $clog2(NUM_W);
	localparam int THR_W = 16;
	localparam int REP_W = 23;
	localparam int MS_W = 10;
	localparam int NEED_W = REP_W + MS_W;
	localparam int TIME_W = 32;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [MS_W-1:0] MS_PER_SECOND = 10'd1000;
	localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd1;
	localparam logic [REP_W-1:0] REPEAT_RESET = 23'd60;

	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_REPEAT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_PREP,
		ST_DIVIDE,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic load;
		logic update;
		logic prep;
		logic step;
		logic decide;
	} ctrl_cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic div_last;
		logic out_free;
	} dp_status_t;

	function automatic logic [VAL_W:0] abs_diff(input logic signed [VAL_W-1:0] a,
			input logic signed [VAL_W-1:0] b);
		logic signed [VAL_W:0] d;
		d = (VAL_W+1)'(a) - (VAL_W+1)'(b);
		return (d < 0) ? (VAL_W+1)'(-d) : (VAL_W+1)'(d);
	endfunction

endpackage
`default_nettype wire

### hw/rtl/mare_ctrl.sv
// controller state machine sequencing window update, divide and publish decision
`timescale 1ns / 1ps
`default_nettype none
module mare_ctrl import mare_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       sample_valid,
	output logic            sample_stall,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid) state_next = ST_UPDATE;
			end
			ST_UPDATE: state_next = ST_PREP;
			ST_PREP: begin
				if (status.cnt_zero) state_next = ST_DECIDE;
				else state_next = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (status.div_last) state_next = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (status.out_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		sample_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
				cmd.load = sample_valid;
			end
			ST_UPDATE: cmd.update = 1'b1;
			ST_PREP: cmd.prep = 1'b1;
			ST_DIVIDE: cmd.step = 1'b1;
			ST_DECIDE: cmd.decide = status.out_free;
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

### hw/rtl/mare_datapath.sv
// datapath: sample window, running sum, serial divider, publish decision, result register
`timescale 1ns / 1ps
`default_nettype none
module mare_datapath import mare_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire ctrl_cmd_t               cmd,
	output dp_status_t                   status,
	input  wire logic [THR_W-1:0]        threshold,
	input  wire logic [REP_W-1:0]        repeat_seconds,
	input  wire logic                    sample_ok,
	input  wire logic signed [VAL_W-1:0] sample_value,
	input  wire logic [TIME_W-1:0]       now_ms,
	output logic                         result_valid,
	input  wire logic                    result_stall,
	output logic                         publish,
	output logic                         last_ok,
	output logic signed [VAL_W-1:0]      last_value,
	output logic                         average_ok,
	output logic signed [VAL_W-1:0]      average_value
);

	logic                    ent_ok_q [STORAGE_SIZE];
	logic signed [VAL_W-1:0] ent_val_q [STORAGE_SIZE];
	logic [IDX_W-1:0]        wp_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        cnt_q;

	logic                    smp_ok_q;
	logic signed [VAL_W-1:0] smp_val_q;
	logic [TIME_W-1:0]       smp_now_q;
	logic [NEED_W-1:0]       need_q;

	logic [NUM_W-1:0]        num_q;
	logic [DEN_W-1:0]        rem_q;
	logic [DEN_W-1:0]        den_q;
	logic                    neg_q;
	logic [DIVC_W-1:0]       div_cnt_q;

	logic                    pub_last_ok_q;
	logic signed [VAL_W-1:0] pub_last_val_q;
	logic signed [VAL_W-1:0] pub_avg_val_q;
	logic [TIME_W-1:0]       pub_time_q;

	logic                    out_valid_q;
	logic                    out_pub_q;
	logic                    out_ok_q;
	logic signed [VAL_W-1:0] out_val_q;
	logic                    out_avg_ok_q;
	logic signed [VAL_W-1:0] out_avg_val_q;

	// window update
	logic [IDX_W-1:0]        wp_next;
	logic                    old_ok;
	logic signed [VAL_W-1:0] old_val;
	logic signed [SUM_W-1:0] sum_next;
	logic [CNT_W-1:0]        cnt_next;

	always_comb begin
		if (wp_q == IDX_W'(STORAGE_SIZE - 1)) wp_next = '0;
		else wp_next = wp_q + IDX_W'(1);
		old_ok = ent_ok_q[wp_next];
		old_val = ent_val_q[wp_next];
		sum_next = sum_q;
		cnt_next = cnt_q;
		if (old_ok) begin
			sum_next = sum_next - SUM_W'(old_val);
			cnt_next = cnt_next - CNT_W'(1);
		end
		if (smp_ok_q) begin
			sum_next = sum_next + SUM_W'(smp_val_q);
			cnt_next = cnt_next + CNT_W'(1);
		end
	end

	// divider set-up and step
	logic [NUM_W-1:0] mag;
	logic [NUM_W-1:0] num_init;
	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DEN_W:0]   rem_sub;

	always_comb begin
		mag = (sum_q < 0) ? NUM_W'(-sum_q) : NUM_W'(sum_q);
		num_init = {mag[NUM_W-2:0], 1'b0} + NUM_W'(cnt_q);
		trial = {rem_q, num_q[NUM_W-1]};
		ge = trial >= {1'b0, den_q};
		rem_sub = trial - {1'b0, den_q};
	end

	// publish decision
	logic                    avg_ok;
	logic [VAL_W-1:0]        q_mag;
	logic signed [VAL_W-1:0] avg_val;
	logic [TIME_W-1:0]       delta;
	logic                    pub;

	always_comb begin
		avg_ok = cnt_q != '0;
		q_mag = num_q[VAL_W-1:0];
		if (!avg_ok) avg_val = '0;
		else if (neg_q) avg_val = -q_mag;
		else avg_val = q_mag;
		delta = smp_now_q - pub_time_q;
		pub = 1'b0;
		if (!smp_ok_q) begin
			pub = 1'b0;
		end else if (!pub_last_ok_q) begin
			pub = 1'b1;
		end else if (pub_last_val_q == smp_val_q) begin
			pub = {1'b0, delta} >= need_q;
		end else if (abs_diff(pub_last_val_q, smp_val_q) >= {1'b0, threshold}) begin
			pub = 1'b1;
		end else if (avg_ok && abs_diff(pub_avg_val_q, avg_val) >= {1'b0, threshold}) begin
			pub = 1'b1;
		end else if (avg_ok && avg_val == smp_val_q) begin
			pub = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORAGE_SIZE; i++) ent_ok_q[i] <= 1'b0;
			wp_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
			pub_last_ok_q <= 1'b0;
			pub_last_val_q <= '0;
			pub_avg_val_q <= '0;
			pub_time_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				ent_ok_q[wp_next] <= smp_ok_q;
				wp_q <= wp_next;
				sum_q <= sum_next;
				cnt_q <= cnt_next;
			end
			if (cmd.decide && pub) begin
				pub_last_ok_q <= smp_ok_q;
				pub_last_val_q <= smp_val_q;
				pub_avg_val_q <= avg_val;
				pub_time_q <= smp_now_q;
			end
			if (cmd.decide) out_valid_q <= 1'b1;
			else if (!result_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			smp_ok_q <= sample_ok;
			smp_val_q <= sample_ok ? sample_value : '0;
			smp_now_q <= now_ms;
		end
		if (cmd.update) begin
			ent_val_q[wp_next] <= smp_val_q;
			need_q <= NEED_W'(repeat_seconds) * NEED_W'(MS_PER_SECOND);
		end
		if (cmd.prep) begin
			neg_q <= sum_q < 0;
			num_q <= num_init;
			rem_q <= '0;
			den_q <= {cnt_q, 1'b0};
			div_cnt_q <= DIVC_W'(NUM_W - 1);
		end
		if (cmd.step) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? rem_sub[DEN_W-1:0] : trial[DEN_W-1:0];
			div_cnt_q <= div_cnt_q - DIVC_W'(1);
		end
		if (cmd.decide) begin
			out_pub_q <= pub;
			out_ok_q <= smp_ok_q;
			out_val_q <= smp_val_q;
			out_avg_ok_q <= avg_ok;
			out_avg_val_q <= avg_val;
		end
	end

	always_comb begin
		status.cnt_zero = cnt_q == '0;
		status.div_last = div_cnt_q == '0;
		status.out_free = !out_valid_q || !result_stall;
	end

	assign result_valid = out_valid_q;
	assign publish = out_pub_q;
	assign last_ok = out_ok_q;
	assign last_value = out_val_q;
	assign average_ok = out_avg_ok_q;
	assign average_value = out_avg_val_q;

endmodule
`default_nettype wire

### hw/rtl/moving_average_report_by_exception_core.sv
// top level: configuration registers, controller and datapath of the deadband averager
//
// usage
// - sample channel: sample_valid / sample_stall carry sample_ok, sample_value, now_ms;
//   a transaction completes on a clock edge with valid high and stall low
// - result channel: result_valid / result_stall carry publish, last_ok, last_value,
//   average_ok and average_value, one result per sample
// - configuration over the apb port: change threshold at 0x0, repeat seconds at 0x4;
//   write only while no sample is in flight
// - sequencing: each sample passes through the update, prep, divide and decide steps
//   before its result enters the output register; prep skips the divide step when the window
//   holds no valid samples. A new sample is taken only after the decide step; the bit-serial
//   divider for the rounded average gives one quotient bit per cycle, 21 bits
// - a finished result waits in the output register; the next sample is taken meanwhile,
//   and its result waits in the decide step until the held one is taken
// - reset clears the window, the running sum and count, the published record and
//   restores the threshold to 1 and the repeat time to 60 seconds
`timescale 1ns / 1ps
`default_nettype none
module moving_average_report_by_exception_core import mare_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [ADDR_W-1:0]       paddr,
	input  wire logic [DATA_W-1:0]       pwdata,
	output logic [DATA_W-1:0]            prdata,
	output logic                         pready,
	input  wire logic                    sample_valid,
	output logic                         sample_stall,
	input  wire logic                    sample_ok,
	input  wire logic signed [VAL_W-1:0] sample_value,
	input  wire logic [TIME_W-1:0]       now_ms,
	output logic                         result_valid,
	input  wire logic                    result_stall,
	output logic                         publish,
	output logic                         last_ok,
	output logic signed [VAL_W-1:0]      last_value,
	output logic                         average_ok,
	output logic signed [VAL_W-1:0]      average_value
);

	logic [THR_W-1:0] thr_q;
	logic [REP_W-1:0] rep_q;
	logic             wr_en;
	ctrl_cmd_t        cmd;
	dp_status_t       status;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
			rep_q <= REPEAT_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_THRESHOLD: thr_q <= pwdata[THR_W-1:0];
				REG_REPEAT: rep_q <= pwdata[REP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_THRESHOLD: prdata = DATA_W'(thr_q);
			REG_REPEAT: prdata = DATA_W'(rep_q);
			default: prdata = '0;
		endcase
	end

	mare_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.status       (status),
		.cmd          (cmd)
	);

	mare_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.threshold      (thr_q),
		.repeat_seconds (rep_q),
		.sample_ok      (sample_ok),
		.sample_value   (sample_value),
		.now_ms         (now_ms),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.publish        (publish),
		.last_ok        (last_ok),
		.last_value     (last_value),
		.average_ok     (average_ok),
		.average_value  (average_value)
	);

endmodule
`default_nettype wire

### dv/moving_average_report_by_exception_core_tb.sv
// self-checking testbench for the deadband moving average core, directed and random samples
`timescale 1ns / 1ps
module moving_average_report_by_exception_core_tb;
	import mare_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 9;
	localparam int SETTLE_CYCLES = 30;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [ADDR_W-1:0] ADDR_THRESHOLD = ADDR_W'(4 * REG_THRESHOLD);
	localparam logic [ADDR_W-1:0] ADDR_REPEAT = ADDR_W'(4 * REG_REPEAT);
	localparam logic [REP_W-1:0] REPEAT_IN_RANGE_MAX = 23'd4294967;

	typedef struct packed {
		logic                    publish;
		logic                    last_ok;
		logic signed [VAL_W-1:0] last_value;
		logic                    average_ok;
		logic signed [VAL_W-1:0] average_value;
	} report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic sample_ok = 1'b0;
	logic signed [VAL_W-1:0] sample_value = '0;
	logic [TIME_W-1:0] now_ms = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic publish;
	logic last_ok;
	logic signed [VAL_W-1:0] last_value;
	logic average_ok;
	logic signed [VAL_W-1:0] average_value;

	// predictor state
	bit window_ok [STORAGE_SIZE];
	int window_val [STORAGE_SIZE];
	int write_pos = 0;
	int window_sum = 0;
	int valid_count = 0;
	bit published_ok = 1'b0;
	int published_val = 0;
	int published_avg = 0;
	bit [TIME_W-1:0] published_ms = '0;
	int cfg_threshold = int'(THRESHOLD_RESET);
	logic [REP_W-1:0] cfg_repeat_s = REPEAT_RESET;

	report_t expected_reports [$];

	int source_gap_pct = 34;
	int sink_stall_pct = 52;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int cycle_count = 0;
	int mismatch_count = 0;
	int samples_accepted = 0;
	int reports_checked = 0;
	int publishes_seen = 0;
	int settings_applied = 0;
	bit [TIME_W-1:0] clock_ms = '0;
	logic signed [VAL_W-1:0] prev_value = '0;

	moving_average_report_by_exception_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.sample_ok     (sample_ok),
		.sample_value  (sample_value),
		.now_ms        (now_ms),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.publish       (publish),
		.last_ok       (last_ok),
		.last_value    (last_value),
		.average_ok    (average_ok),
		.average_value (average_value)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("run stopped at cycle limit %0d", CYCLE_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// result side: random stalls plus an occasional long hold-off
	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < sink_stall_pct);
		end
	end

	function automatic int value_gap(input int a, input int b);
		return (a >= b) ? a - b : b - a;
	endfunction

	function automatic report_t predict_report(input logic ok,
			input logic signed [VAL_W-1:0] value, input logic [TIME_W-1:0] now);
		report_t r;
		int val, mag, quo, avg;
		logic avg_ok, pub;
		logic [TIME_W-1:0] elapsed;
		logic [63:0] needed;
		val = ok ? int'(value) : 0;
		write_pos = (write_pos + 1) % STORAGE_SIZE;
		if (window_ok[write_pos]) begin
			window_sum -= window_val[write_pos];
			valid_count--;
		end
		window_ok[write_pos] = ok;
		window_val[write_pos] = val;
		if (ok) begin
			window_sum += val;
			valid_count++;
		end
		avg_ok = (valid_count > 0);
		avg = 0;
		if (avg_ok) begin
			mag = (window_sum < 0) ? -window_sum : window_sum;
			quo = (2 * mag + valid_count) / (2 * valid_count);
			avg = (window_sum < 0) ? -quo : quo;
		end
		pub = 1'b0;
		if (!ok) begin
			pub = 1'b0;
		end else if (!published_ok) begin
			pub = 1'b1;
		end else if (published_val == val) begin
			elapsed = now - published_ms;
			needed = 64'(cfg_repeat_s) * 64'(MS_PER_SECOND);
			pub = (64'(elapsed) >= needed);
		end else if (value_gap(published_val, val) >= cfg_threshold) begin
			pub = 1'b1;
		end else if (avg_ok && value_gap(published_avg, avg) >= cfg_threshold) begin
			pub = 1'b1;
		end else if (avg_ok && avg == val) begin
			pub = 1'b1;
		end
		if (pub) begin
			published_ms = now;
			published_avg = avg;
			published_ok = 1'b1;
			published_val = val;
		end
		r.publish = pub;
		r.last_ok = ok;
		r.last_value = VAL_W'(val);
		r.average_ok = avg_ok;
		r.average_value = VAL_W'(avg);
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			mismatch_count++;
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : report_monitor
		report_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_reports.size() == 0) begin
					mismatch_count++;
					$display("%0t ns: report with nothing expected, got publish %0b last %0d avg %0d",
						$time, publish, last_value, average_value);
				end else begin
					want = expected_reports.pop_front();
					check_field("publish", int'(want.publish), int'(publish));
					check_field("last_ok", int'(want.last_ok), int'(last_ok));
					check_field("last_value", int'(want.last_value), int'(last_value));
					check_field("average_ok", int'(want.average_ok), int'(average_ok));
					check_field("average_value", int'(want.average_value),
						int'(average_value));
					reports_checked++;
					if (want.publish)
						publishes_seen++;
				end
			end
			if (sample_valid && !sample_stall) begin
				expected_reports.push_back(predict_report(sample_ok, sample_value, now_ms));
				samples_accepted++;
			end
		end
	end

	task automatic send_sample(input logic ok, input logic signed [VAL_W-1:0] value,
			input logic [TIME_W-1:0] now);
		if ($urandom_range(0, 99) < source_gap_pct) begin
			sample_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < source_gap_pct);
		end
		sample_valid <= 1'b1;
		sample_ok <= ok;
		sample_value <= value;
		now_ms <= now;
		do @(posedge clk); while (sample_stall);
	endtask

	// drain every outstanding transaction and let the core go idle
	task automatic quiesce();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		if (addr == ADDR_THRESHOLD)
			cfg_threshold = int'(data[THR_W-1:0]);
		else if (addr == ADDR_REPEAT)
			cfg_repeat_s = data[REP_W-1:0];
	endtask

	task automatic set_registers(input logic [DATA_W-1:0] threshold,
			input logic [DATA_W-1:0] repeat_s);
		quiesce();
		write_reg(ADDR_THRESHOLD, threshold);
		write_reg(ADDR_REPEAT, repeat_s);
		settings_applied++;
	endtask

	// reset values of the registers, first publish, repeat timer and its wrap
	task automatic test_reset_defaults();
		send_sample(1'b0, 16'sh7FFF, 32'd0);
		send_sample(1'b1, 16'sh8000, 32'd100);
		send_sample(1'b1, 16'sh8000, 32'd60099);
		send_sample(1'b1, 16'sh8000, 32'd60100);
		send_sample(1'b1, 16'sh7FFF, 32'hFFFF_FF00);
		send_sample(1'b1, 16'sh7FFF, 32'h0000_E95F);
		send_sample(1'b1, 16'sh7FFF, 32'h0000_E960);
	endtask

	// changes just below and at the threshold, invalid reads in between
	task automatic test_deadband_decisions();
		set_registers(32'd100, 32'd5);
		send_sample(1'b1, 16'sd0, 32'd10000);
		send_sample(1'b0, 16'sd1234, 32'd10100);
		send_sample(1'b1, 16'sd99, 32'd10200);
		send_sample(1'b1, 16'sd100, 32'd10300);
		send_sample(1'b1, -16'sd100, 32'd10400);
		send_sample(1'b1, -16'sd150, 32'd10500);
	endtask

	// zero threshold and repeat, full-scale threshold, repeat beyond 32-bit milliseconds
	task automatic test_register_extremes();
		set_registers(32'd0, 32'd0);
		send_sample(1'b1, -16'sd32767, 32'd20000);
		send_sample(1'b1, 16'sh8000, 32'd20000);
		send_sample(1'b1, 16'sh8000, 32'd20000);
		set_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_sample(1'b1, 16'sh7FFF, 32'd30001);
		send_sample(1'b1, 16'sh7FFE, 32'd30002);
		send_sample(1'b1, 16'sh7FFF, 32'd30000);
		set_registers(32'd1, 32'(REPEAT_IN_RANGE_MAX));
		send_sample(1'b1, 16'sh7FFF, 32'd29192);
		send_sample(1'b1, 16'sh7FFF, 32'd29193);
		clock_ms = 32'd50000;
	endtask

	task automatic test_random_traffic(input int count, input int gap_pct, input int stall_pct);
		int n, span;
		logic ok;
		logic signed [VAL_W-1:0] value;
		logic [DATA_W-1:0] thr, rep;
		source_gap_pct = gap_pct;
		sink_stall_pct = stall_pct;
		for (n = 0; n < count; n++) begin
			if (n % 50 == 0) begin
				case ($urandom_range(0, 5))
					0: thr = 0;
					1: thr = 32'h0000_FFFF;
					2, 3: thr = $urandom_range(1, 20);
					4: thr = $urandom_range(21, 2000);
					default: thr = $urandom_range(0, 16'hFFFF);
				endcase
				case ($urandom_range(0, 5))
					0: rep = 0;
					1: rep = 32'h007F_FFFF;
					2: rep = 32'(REPEAT_IN_RANGE_MAX);
					default: rep = $urandom_range(1, 90);
				endcase
				set_registers(thr, rep);
			end
			span = (cfg_threshold > 200) ? 200 : cfg_threshold + 2;
			ok = 1'b1;
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5:
					value = prev_value + VAL_W'(int'($urandom_range(0, 2 * span)) - span);
				6, 7, 8, 9: value = prev_value;
				10, 11: value = VAL_W'(published_avg);
				12, 13, 14: value = VAL_W'($urandom);
				15: begin
					case ($urandom_range(0, 3))
						0: value = 16'sh8000;
						1: value = 16'sh7FFF;
						2: value = 16'sh0000;
						default: value = 16'shFFFF;
					endcase
				end
				16, 17: begin
					ok = 1'b0;
					value = VAL_W'($urandom);
				end
				default: value = VAL_W'(published_avg + int'($urandom_range(0, 2 * span)) - span);
			endcase
			// mostly small steps, some long gaps, timer boundaries and wraps
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: clock_ms += $urandom_range(0, 3000);
				12, 13, 14, 15: clock_ms += $urandom_range(3000, 120000);
				16, 17: clock_ms = published_ms + 32'(cfg_repeat_s) * 32'(MS_PER_SECOND)
					+ 32'($urandom_range(0, 2)) - 32'd1;
				18: clock_ms += $urandom;
				default: clock_ms = clock_ms;
			endcase
			send_sample(ok, value, clock_ms);
			if (ok)
				prev_value = value;
		end
	endtask

	// long result hold-off while samples keep coming, so the input side backs up
	task automatic test_output_backpressure();
		int n;
		source_gap_pct = 0;
		sink_stall_pct = 0;
		hold_request = 1'b1;
		for (n = 0; n < 12; n++) begin
			clock_ms += 500;
			prev_value = prev_value + VAL_W'(int'($urandom_range(0, 6)) - 3);
			send_sample(1'b1, prev_value, clock_ms);
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_deadband_decisions();
		test_register_extremes();
		test_random_traffic(250, 34, 52);
		test_random_traffic(250, 52, 34);
		test_random_traffic(250, 0, 0);
		test_output_backpressure();
		quiesce();
		$display("covered %0d samples, %0d reports checked, %0d publishes, %0d register settings",
			samples_accepted, reports_checked, publishes_seen, settings_applied);
		$display("traffic: sparse sender with busy receiver, the reverse, back-to-back, one long hold-off");
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/mare_pkg.sv
hw/rtl/mare_ctrl.sv
hw/rtl/mare_datapath.sv
hw/rtl/moving_average_report_by_exception_core.sv
dv/moving_average_report_by_exception_core_tb.sv
